// ----- hdl/uera_pkg.sv -----
// shared types and constants for the ultrasonic echo ranger
package uera_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_TRIGGER_TICKS   = 3'd0;
    localparam logic [2:0] CFG_ECHO_WAIT_LIMIT = 3'd1;
    localparam logic [2:0] CFG_ECHO_MAX_TICKS  = 3'd2;
    localparam logic [2:0] CFG_MAX_DISTANCE_CM = 3'd3;
    localparam logic [2:0] CFG_ALPHA           = 3'd4;
    localparam logic [2:0] CFG_ONE_MINUS_ALPHA = 3'd5;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_TRIGGER_TICKS   = 8'd10;
    localparam logic [15:0] RST_ECHO_WAIT_LIMIT = 16'd5000;
    localparam logic [15:0] RST_ECHO_MAX_TICKS  = 16'd2900;
    localparam logic [10:0] RST_MAX_DISTANCE_CM = 11'd50;
    localparam logic [8:0]  RST_ALPHA           = 9'd192;
    localparam logic [8:0]  RST_ONE_MINUS_ALPHA = 9'd64;

    // divide by 58 as multiply by ceil(2^22 / 58), exact for 16-bit counts
    localparam int          DIV_SHIFT = 22;
    localparam logic [16:0] DIV_RECIP = 17'd72316;
    localparam int          PROD_W    = 33;

    localparam logic [10:0] FILT_MAX = 11'd2047;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic start_req;
        logic echo;
    } in_word_t;

    typedef struct packed {
        logic        trigger_level;
        logic        done_res;
        logic [10:0] raw_cm;
        logic [10:0] filtered_cm;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  trigger_ticks;
        logic [15:0] echo_wait_limit;
        logic [15:0] echo_max_ticks;
        logic [10:0] max_distance_cm;
        logic [8:0]  alpha;
        logic [8:0]  one_minus_alpha;
    } cfg_t;

    // classified tick passed from front to back
    typedef struct packed {
        logic        trig;
        logic        done;
        logic        zero;
        logic [15:0] count;
    } task_t;

endpackage

// ----- hdl/uera_front.sv -----
// tick sequencer: trigger, echo wait and echo timing phases
module uera_front (
    input  logic              clk,
    input  logic              rst_n,
    input  uera_pkg::cfg_t    cfg,
    input  logic              tick_en,
    input  uera_pkg::in_word_t tick_word,
    output uera_pkg::task_t   task_word
);
    import uera_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] limit;
    logic [15:0] count_inc;
    task_t       tw;

    assign limit     = (cfg.trigger_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.trigger_ticks};
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        tw         = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (tick_word.start_req)
                begin
                    tw.trig = 1'b1;
                    if (16'd1 >= limit)
                    begin
                        phase_next = PH_WAIT;
                        count_next = 16'd0;
                    end
                    else
                    begin
                        phase_next = PH_TRIG;
                        count_next = 16'd1;
                    end
                end
            end
            PH_TRIG:
            begin
                tw.trig = 1'b1;
                if (count_inc >= limit)
                begin
                    phase_next = PH_WAIT;
                    count_next = 16'd0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_WAIT:
            begin
                if (!tick_word.echo)
                begin
                    if (count_reg >= cfg.echo_wait_limit)
                    begin
                        tw.done = 1'b1;
                        tw.zero = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                else if (cfg.echo_max_ticks == 16'd0)
                begin
                    tw.done = 1'b1;
                    tw.zero = 1'b1;
                end
                else
                begin
                    // first high tick counts as one
                    phase_next = PH_MEAS;
                    count_next = 16'd1;
                end
            end
            PH_MEAS:
            begin
                if (tick_word.echo)
                begin
                    if (count_reg >= cfg.echo_max_ticks)
                    begin
                        tw.done = 1'b1;
                        tw.zero = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                else
                begin
                    tw.done  = 1'b1;
                    tw.count = count_reg;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                count_next = 16'd0;
            end
        endcase
        if (tw.done)
        begin
            phase_next = PH_IDLE;
            count_next = 16'd0;
        end
    end

    assign task_word = tw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= 16'd0;
        end
        else if (tick_en)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/uera_queue.sv -----
// four entry queue of classified ticks between front and back
module uera_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  uera_pkg::task_t  push_word,
    output logic             full,
    output logic             nonempty,
    input  logic             pop,
    output uera_pkg::task_t  pop_word
);
    import uera_pkg::*;

    task_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign pop_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hdl/uera_back.sv -----
// back pipeline: divide by 58, range check, exponential filter, output register
module uera_back (
    input  logic               clk,
    input  logic               rst_n,
    input  uera_pkg::cfg_t     cfg,
    input  logic               q_nonempty,
    input  uera_pkg::task_t    q_word,
    output logic               q_pop,
    output logic               res_valid,
    input  logic               res_stall,
    output uera_pkg::out_word_t res_word
);
    import uera_pkg::*;

    logic              en;

    logic              s1_valid_reg;
    logic              s1_trig_reg;
    logic              s1_done_reg;
    logic              s1_zero_reg;
    logic [PROD_W-1:0] s1_prod_reg;

    logic              s2_valid_reg;
    logic              s2_trig_reg;
    logic              s2_done_reg;
    logic [10:0]       s2_raw_reg;
    logic [19:0]       s2_wnew_reg;

    logic              out_valid_reg;
    out_word_t         out_reg, out_next;

    logic [10:0]       filt_reg, filt_next;
    logic              primed_reg, primed_next;

    logic [10:0]       quot;
    logic [10:0]       raw_c;
    logic [19:0]       wold;
    logic [20:0]       acc;
    logic [12:0]       acc_sh;

    assign en    = !out_valid_reg || !res_stall;
    assign q_pop = en && q_nonempty;

    // stage 2 quotient and range check
    assign quot  = s1_prod_reg[PROD_W-1:DIV_SHIFT];
    assign raw_c = (s1_zero_reg || (quot > cfg.max_distance_cm)) ? 11'd0 : quot;

    // stage 3 filter
    assign wold   = 20'(cfg.one_minus_alpha) * 20'(filt_reg);
    assign acc    = 21'(s2_wnew_reg) + 21'(wold);
    assign acc_sh = acc[20:8];

    always_comb
    begin
        filt_next   = filt_reg;
        primed_next = primed_reg;
        out_next    = '0;
        out_next.trigger_level = s2_trig_reg;
        if (s2_valid_reg && s2_done_reg)
        begin
            if (s2_raw_reg == 11'd0)
            begin
                filt_next   = 11'd0;
                primed_next = 1'b0;
            end
            else if (!primed_reg)
            begin
                filt_next   = s2_raw_reg;
                primed_next = 1'b1;
            end
            else if (acc_sh > 13'(FILT_MAX))
            begin
                filt_next = FILT_MAX;
            end
            else
            begin
                filt_next = acc_sh[10:0];
            end
            out_next.done_res    = 1'b1;
            out_next.raw_cm      = s2_raw_reg;
            out_next.filtered_cm = filt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (q_nonempty)
            begin
                s1_trig_reg <= q_word.trig;
                s1_done_reg <= q_word.done;
                s1_zero_reg <= q_word.zero;
                s1_prod_reg <= PROD_W'(q_word.count) * PROD_W'(DIV_RECIP);
            end
            if (s1_valid_reg)
            begin
                s2_trig_reg <= s1_trig_reg;
                s2_done_reg <= s1_done_reg;
                s2_raw_reg  <= raw_c;
                s2_wnew_reg <= 20'(cfg.alpha) * 20'(raw_c);
            end
            if (s2_valid_reg)
                out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filt_reg      <= 11'd0;
            primed_reg    <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_nonempty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                filt_reg   <= filt_next;
                primed_reg <= primed_next;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

endmodule

// ----- hdl/ultrasonic_echo_ranger_ema.sv -----
// top level of the ultrasonic echo ranger with exponential smoothing
//
// usage
// - src channel: one word per 1 us tick, carrying start_req and the echo pin level;
//   a word is taken on a rising edge with src_valid high and src_stall low
// - res channel: exactly one word per accepted tick, in order, holding the trigger
//   level, the done flag and on done the raw and filtered distance in cm
// - cfg channel: register index and data, taken when cfg_valid and cfg_ready are high;
//   cfg_ready is always high, writes only while no tick is in flight
// - throughput: one tick per cycle, sustained as long as res_stall stays low
// - path: a taken tick passes the queue write, the divide multiply stage, the weight
//   multiply stage and the filter and output register before it shows up on res
// - the phase sequencer runs at the input side; a four word queue lets it keep
//   taking ticks while the back pipeline is held by res_stall
// - when the receiver stalls a valid word, that word holds and the back pipeline freezes;
//   src_stall rises once the queue is full
// - reset: registers return to their default values, phase idle, filter cleared and
//   unprimed, queue and pipeline empty
module ultrasonic_echo_ranger_ema (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  uera_pkg::in_word_t  src_word,
    output logic                res_valid,
    input  logic                res_stall,
    output uera_pkg::out_word_t res_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import uera_pkg::*;

    cfg_t  cfg_reg;
    logic  q_full;
    logic  q_nonempty;
    logic  q_pop;
    logic  tick_en;
    task_t front_word;
    task_t q_word;

    assign cfg_ready = 1'b1;

    // a tick is taken whenever the queue has room
    assign src_stall = q_full;
    assign tick_en   = src_valid && !q_full;

    // configuration register file, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks   <= RST_TRIGGER_TICKS;
            cfg_reg.echo_wait_limit <= RST_ECHO_WAIT_LIMIT;
            cfg_reg.echo_max_ticks  <= RST_ECHO_MAX_TICKS;
            cfg_reg.max_distance_cm <= RST_MAX_DISTANCE_CM;
            cfg_reg.alpha           <= RST_ALPHA;
            cfg_reg.one_minus_alpha <= RST_ONE_MINUS_ALPHA;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TRIGGER_TICKS:   cfg_reg.trigger_ticks   <= cfg_data[7:0];
                CFG_ECHO_WAIT_LIMIT: cfg_reg.echo_wait_limit <= cfg_data;
                CFG_ECHO_MAX_TICKS:  cfg_reg.echo_max_ticks  <= cfg_data;
                CFG_MAX_DISTANCE_CM: cfg_reg.max_distance_cm <= cfg_data[10:0];
                CFG_ALPHA:           cfg_reg.alpha           <= cfg_data[8:0];
                CFG_ONE_MINUS_ALPHA: cfg_reg.one_minus_alpha <= cfg_data[8:0];
                default:             ;
            endcase
        end
    end

    // phase sequencer, classifies each tick
    uera_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tick_en   (tick_en),
        .tick_word (src_word),
        .task_word (front_word)
    );

    // decouples the sequencer from the arithmetic
    uera_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tick_en),
        .push_word (front_word),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .pop       (q_pop),
        .pop_word  (q_word)
    );

    // distance, range check and filter
    uera_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_nonempty (q_nonempty),
        .q_word     (q_word),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_word   (res_word)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the ultrasonic echo ranger with exponential smoothing
`timescale 1ns / 1ps

module tb_top;
    import uera_pkg::*;

    // sequencer phases of the tick-level predictor
    typedef enum logic [1:0] {
        RANGER_IDLE,
        RANGER_TRIG,
        RANGER_WAIT,
        RANGER_MEAS
    } ranger_phase_e;

    // register indexes past the end of the map, writes there must be dropped
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam int unsigned US_PER_CM   = 58;   // echo microseconds per centimeter
    localparam int unsigned IDLE_PCT    = 13;   // chance of a gap on either side
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    in_word_t  src_word  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_word_t res_word;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [2:0]  cfg_index = CFG_TRIGGER_TICKS;
    logic [15:0] cfg_data  = '0;

    ultrasonic_echo_ranger_ema dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the register file and of the ranger state
    cfg_t          shadow_cfg = '{RST_TRIGGER_TICKS, RST_ECHO_WAIT_LIMIT, RST_ECHO_MAX_TICKS,
                                  RST_MAX_DISTANCE_CM, RST_ALPHA, RST_ONE_MINUS_ALPHA};
    ranger_phase_e seq_phase     = RANGER_IDLE;
    logic [15:0]   seq_count     = '0;
    logic [10:0]   smooth_value  = '0;
    logic          smooth_primed = 1'b0;

    // result words still owed by the block, oldest first
    out_word_t predicted_words[$];

    bit no_gaps      = 1'b0;
    int errors       = 0;
    int ticks_sent   = 0;
    int done_seen    = 0;
    int ranged_seen  = 0;
    int satur_seen   = 0;

    // exponential smoothing of one finished reading
    function automatic logic [10:0] smooth_reading(input logic [10:0] raw);
        logic [31:0] acc;
        if (!smooth_primed)
        begin
            // first reading after reset or after a miss loads straight in
            smooth_value  = raw;
            smooth_primed = 1'b1;
        end
        else
        begin
            acc = (32'(shadow_cfg.alpha) * 32'(raw)
                 + 32'(shadow_cfg.one_minus_alpha) * 32'(smooth_value)) >> 8;
            smooth_value = (acc > 32'(FILT_MAX)) ? FILT_MAX : acc[10:0];
        end
        // a miss clears the filter and unprimes it
        if (raw == '0)
        begin
            smooth_value  = '0;
            smooth_primed = 1'b0;
        end
        return smooth_value;
    endfunction

    // advance the shadow ranger by one tick and return the word it should emit
    function automatic out_word_t ranger_step(input in_word_t w);
        out_word_t   r;
        logic [15:0] trig_len;
        logic [15:0] range_cm;
        logic        fin;
        r        = '0;
        fin      = 1'b0;
        range_cm = '0;
        // a zero trigger length still gives a one tick pulse
        trig_len = (shadow_cfg.trigger_ticks == '0) ? 16'd1 : 16'(shadow_cfg.trigger_ticks);
        case (seq_phase)
            RANGER_IDLE:
            begin
                if (w.start_req)
                begin
                    r.trigger_level = 1'b1;
                    seq_count       = 16'd1;
                    if (seq_count >= trig_len)
                    begin
                        seq_phase = RANGER_WAIT;
                        seq_count = '0;
                    end
                    else
                    begin
                        seq_phase = RANGER_TRIG;
                    end
                end
            end
            RANGER_TRIG:
            begin
                r.trigger_level = 1'b1;
                seq_count       = seq_count + 16'd1;
                if (seq_count >= trig_len)
                begin
                    seq_phase = RANGER_WAIT;
                    seq_count = '0;
                end
            end
            RANGER_WAIT:
            begin
                if (!w.echo)
                begin
                    if (seq_count >= shadow_cfg.echo_wait_limit)
                        fin = 1'b1;
                    else
                        seq_count = seq_count + 16'd1;
                end
                else
                begin
                    // rising echo counts as the first high tick
                    seq_phase = RANGER_MEAS;
                    seq_count = '0;
                    if (shadow_cfg.echo_max_ticks == '0)
                        fin = 1'b1;
                    else
                        seq_count = 16'd1;
                end
            end
            default:
            begin
                if (w.echo)
                begin
                    if (seq_count >= shadow_cfg.echo_max_ticks)
                        fin = 1'b1;
                    else
                        seq_count = seq_count + 16'd1;
                end
                else
                begin
                    fin      = 1'b1;
                    range_cm = seq_count / 16'(US_PER_CM);
                    if (range_cm > 16'(shadow_cfg.max_distance_cm))
                        range_cm = '0;
                end
            end
        endcase
        if (fin)
        begin
            r.done_res    = 1'b1;
            r.raw_cm      = range_cm[10:0];
            r.filtered_cm = smooth_reading(range_cm[10:0]);
            seq_phase     = RANGER_IDLE;
            seq_count     = '0;
        end
        return r;
    endfunction

    // register write as the block should see it, index beyond the map ignored
    function automatic void shadow_write(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            CFG_TRIGGER_TICKS:   shadow_cfg.trigger_ticks   = data[7:0];
            CFG_ECHO_WAIT_LIMIT: shadow_cfg.echo_wait_limit = data;
            CFG_ECHO_MAX_TICKS:  shadow_cfg.echo_max_ticks  = data;
            CFG_MAX_DISTANCE_CM: shadow_cfg.max_distance_cm = data[10:0];
            CFG_ALPHA:           shadow_cfg.alpha           = data[8:0];
            CFG_ONE_MINUS_ALPHA: shadow_cfg.one_minus_alpha = data[8:0];
            default: ;
        endcase
    endfunction

    function automatic bit gap_roll();
        return !no_gaps && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // receiver side: random stall, none while a gap-free stretch runs
    always @(posedge clk)
        res_stall <= gap_roll();

    // result checker, samples the handshake as it stood before the edge
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (predicted_words.size() == 0)
            begin
                $error("result word with nothing outstanding: %h", res_word);
                errors++;
            end
            else
            begin
                want = predicted_words.pop_front();
                if (res_word.trigger_level !== want.trigger_level)
                begin
                    $error("trigger_level: expected %0d, got %0d",
                           want.trigger_level, res_word.trigger_level);
                    errors++;
                end
                if (res_word.done_res !== want.done_res)
                begin
                    $error("done_res: expected %0d, got %0d", want.done_res, res_word.done_res);
                    errors++;
                end
                if (res_word.raw_cm !== want.raw_cm)
                begin
                    $error("raw_cm: expected %0d, got %0d", want.raw_cm, res_word.raw_cm);
                    errors++;
                end
                if (res_word.filtered_cm !== want.filtered_cm)
                begin
                    $error("filtered_cm: expected %0d, got %0d",
                           want.filtered_cm, res_word.filtered_cm);
                    errors++;
                end
                if (want.done_res)
                begin
                    done_seen++;
                    if (want.raw_cm != '0)
                        ranged_seen++;
                    if (want.filtered_cm == FILT_MAX)
                        satur_seen++;
                end
            end
        end
    end

    // one tick word: optional gap, then hold until taken, then predict
    task automatic send_tick(input logic start, input logic echo_lvl);
        in_word_t w;
        w.start_req = start;
        w.echo      = echo_lvl;
        while (gap_roll())
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= w;
        do
            @(posedge clk);
        while (src_stall !== 1'b0);
        predicted_words.push_back(ranger_step(w));
        ticks_sent++;
    endtask

    // sender pause until every owed word is back, then let the pipe settle
    task automatic wait_results_drained();
        src_valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // close any open measurement so that registers change only while idle
    task automatic drain_to_idle();
        while (seq_phase != RANGER_IDLE)
            send_tick(1'($urandom), seq_phase == RANGER_WAIT);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        shadow_write(idx, data);
    endtask

    // full register set plus two writes to unused indexes
    task automatic set_ranger_config(input logic [15:0] trig, input logic [15:0] wait_lim,
                                     input logic [15:0] tmo, input logic [15:0] max_cm,
                                     input logic [15:0] a, input logic [15:0] oma);
        drain_to_idle();
        wait_results_drained();
        cfg_write(CFG_TRIGGER_TICKS, trig);
        cfg_write(CFG_ECHO_WAIT_LIMIT, wait_lim);
        cfg_write(CFG_ECHO_MAX_TICKS, tmo);
        cfg_write(CFG_MAX_DISTANCE_CM, max_cm);
        cfg_write(CFG_ALPHA, a);
        cfg_write(CFG_ONE_MINUS_ALPHA, oma);
        cfg_write(CFG_SPARE_LO, 16'($urandom));
        cfg_write(CFG_SPARE_HI, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // well formed measurement: start, trigger ticks, some low ticks, an echo pulse
    // start and echo during the trigger are random, busy starts must be ignored
    task automatic run_measurement(input int unsigned low_ticks, input int unsigned high_ticks);
        int unsigned lows_sent;
        int unsigned highs_sent;
        lows_sent  = 0;
        highs_sent = 0;
        send_tick(1'b1, 1'($urandom));
        while (seq_phase != RANGER_IDLE)
        begin
            case (seq_phase)
                RANGER_TRIG:
                    send_tick(1'($urandom), 1'($urandom));
                RANGER_WAIT:
                begin
                    if (lows_sent < low_ticks)
                    begin
                        lows_sent++;
                        send_tick(1'($urandom), 1'b0);
                    end
                    else
                    begin
                        highs_sent++;
                        send_tick(1'($urandom), 1'b1);
                    end
                end
                default:
                begin
                    if (highs_sent < high_ticks)
                    begin
                        highs_sent++;
                        send_tick(1'($urandom), 1'b1);
                    end
                    else
                    begin
                        send_tick(1'($urandom), 1'b0);
                    end
                end
            endcase
        end
    endtask

    // mostly measurements with random timing, the rest bursts of random ticks
    // long_only keeps every pulse at one centimeter so the filter never resets
    task automatic random_round(input int n_ticks, input bit long_only,
                                input int unsigned noise_pct, input int unsigned max_low);
        int stop_at;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at)
        begin
            if ($urandom_range(99) < noise_pct)
                repeat ($urandom_range(1, 6)) send_tick(1'($urandom), 1'($urandom));
            else if (long_only)
                run_measurement($urandom_range(0, max_low), $urandom_range(58, 60));
            else if ($urandom_range(1))
                run_measurement($urandom_range(0, max_low), $urandom_range(1, 30));
            else
                run_measurement($urandom_range(0, max_low), $urandom_range(58, 180));
        end
    endtask

    // zero registers, one tick trigger, misses at both limits, busy starts
    task automatic test_directed();
        // trigger length masked to zero, treated as a single tick
        set_ranger_config(16'h0100, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_tick(1'b0, 1'b1);      // idle echo is ignored
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);      // single tick trigger
        send_tick(1'b0, 1'b0);      // no wait allowed, immediate miss
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);      // echo rises but zero timeout, miss
        set_ranger_config(16'd3, 16'd2, 16'd3, 16'd1129, 16'd256, 16'd256);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);      // start while busy
        send_tick(1'b0, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0);   // wait limit runs out exactly
        repeat (3) send_tick(1'b1, 1'b0);
        repeat (2) send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b0, 1'b1);   // longest accepted echo
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        repeat (2) send_tick(1'b0, 1'b1);
        repeat (4) send_tick(1'b0, 1'b1);   // one high tick too many
    endtask

    // reset-like weights, short waits, a mix of misses and short ranges
    task automatic test_everyday();
        set_ranger_config(16'($urandom_range(1, 8)), 16'd20, 16'd150, 16'd2,
                          16'(RST_ALPHA), 16'(RST_ONE_MINUS_ALPHA));
        random_round(30, 1'b0, 25, 24);
    endtask

    // largest wait and timeout registers, distance limit at the top reachable range, back to back with no gaps
    task automatic test_extremes();
        no_gaps = 1'b1;
        set_ranger_config(16'd2, 16'hFFFF, 16'hFFFF, 16'd1129, 16'd256, 16'd0);
        random_round(80, 1'b0, 10, 20);
        // a one centimeter reading leaves the filter primed at one
        drain_to_idle();
        run_measurement($urandom_range(0, 20), $urandom_range(58, 70));
        no_gaps = 1'b0;
    endtask

    // oversized weights roughly double the filter each reading until it saturates
    task automatic test_filter_saturation();
        set_ranger_config(16'd1, 16'd2, 16'd100, 16'd1, 16'd511, 16'd511);
        random_round(640, 1'b1, 0, 0);
    endtask

    // random trigger length, all weight on history, tight distance limit
    task automatic test_history_weight();
        set_ranger_config(16'($urandom_range(1, 4)), 16'd8, 16'd130, 16'd1, 16'd0, 16'd256);
        random_round(20, 1'b0, 30, 12);
    endtask

    // watchdog on a hung handshake
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[ultrasonic_echo_ranger_ema] ERROR");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_everyday();
        test_extremes();
        test_filter_saturation();
        test_history_weight();
        drain_to_idle();
        wait_results_drained();
        repeat (8) @(posedge clk);
        $display("ran %0d ticks: %0d measurements finished, %0d with a distance,",
                 ticks_sent, done_seen, ranged_seen);
        $display("filter at full scale %0d times, %0d mismatches", satur_seen, errors);
        if (errors == 0)
            $display("[ultrasonic_echo_ranger_ema] OK");
        else
            $display("[ultrasonic_echo_ranger_ema] ERROR");
        $finish;
    end

endmodule
